// File: sv/ppp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared types and constants of the pixel packetizer: register indexes,
// depth codes, the per-pixel byte command and the channel reduce function.
// ----------------------------------------------------------------------------
package ppp_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_DEPTH_MODE  = 2'd0;
  localparam logic [1:0] REG_PACKET_MODE = 2'd1;
  localparam logic [1:0] REG_PIX_PER_PKT = 2'd2;
  localparam logic [1:0] REG_PROTO_TYPE  = 2'd3;

  // depth mode codes (any other code copies bytes through)
  localparam logic [1:0] DEPTH_COPY = 2'd0;
  localparam logic [1:0] DEPTH_4BIT = 2'd1;
  localparam logic [1:0] DEPTH_3BIT = 2'd2;

  // packet mode codes
  localparam logic PKT_ROW    = 1'b0;
  localparam logic PKT_WINDOW = 1'b1;

  // register reset values
  localparam logic [1:0]  DEPTH_RST = DEPTH_4BIT;
  localparam logic [12:0] PPP_RST   = 13'd256;

  // bytes one pixel can cause: two header bytes and up to three payload bytes
  localparam int unsigned MAX_BYTES = 5;
  localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // rounding constants of the two reduce modes
  localparam logic [15:0] MUL4 = 16'd15;
  localparam logic [15:0] ADD4 = 16'd135;
  localparam logic [15:0] MUL3 = 16'd225;
  localparam logic [15:0] ADD3 = 16'd4096;

  // one pixel worth of stream bytes, in output order
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          n;
    logic                      has_hdr;
    logic                      last;
  } cmd_t;

  // multiply, add and shift rounding of one channel
  function automatic logic [3:0] cut_channel(input logic [7:0] c, input logic [1:0] mode);
    logic [15:0] p;
    logic [3:0]  res;
    if (mode == DEPTH_3BIT) begin
      p   = {8'd0, c} * MUL3 + ADD3;
      res = {1'b0, p[15:13]};
    end else begin
      p   = {8'd0, c} * MUL4 + ADD4;
      res = p[11:8];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: sv/ppp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppp_front
// Accepts pixels, holds configuration and packet state, reduces channels and
// builds the byte command that one pixel causes.
// ----------------------------------------------------------------------------
module ppp_front #(
  parameter int unsigned NIBBLE_SHIFT = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [12:0]   cfg_wdata,
  input  wire logic          in_valid,
  input  wire logic [7:0]    in_red,
  input  wire logic [7:0]    in_green,
  input  wire logic [7:0]    in_blue,
  input  wire logic          in_end_of_frame,
  input  wire logic          q_full,
  output logic               push,
  output ppp_pkg::cmd_t      cmd
);
  import ppp_pkg::*;

  logic [1:0]  depth_mode_r;
  logic        packet_mode_r;
  logic [12:0] pix_per_pkt_r;
  logic [7:0]  proto_type_r;

  logic [7:0]  pending_r, pending_nxt;
  logic        phase_r, phase_nxt;
  logic [12:0] pix_cnt_r, pix_cnt_nxt;
  logic [7:0]  pkt_num_r, pkt_num_nxt;

  logic        reduce, full, close, hdr;
  logic [3:0]  cr, cg, cb;
  logic [7:0]  pend_new;
  logic [2:0][7:0] pay;
  logic [CNT_W-1:0] pay_n;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_mode_r  <= DEPTH_RST;
      packet_mode_r <= PKT_ROW;
      pix_per_pkt_r <= PPP_RST;
      proto_type_r  <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEPTH_MODE:  depth_mode_r  <= cfg_wdata[1:0];
        REG_PACKET_MODE: packet_mode_r <= cfg_wdata[0];
        REG_PIX_PER_PKT: pix_per_pkt_r <= cfg_wdata;
        REG_PROTO_TYPE:  proto_type_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign push = in_valid && !q_full;

  // channel reduce
  assign cr = cut_channel(in_red, depth_mode_r);
  assign cg = cut_channel(in_green, depth_mode_r);
  assign cb = cut_channel(in_blue, depth_mode_r);
  assign pend_new = 8'({4'd0, cb} << NIBBLE_SHIFT);

  // packet boundary decisions
  assign reduce = (depth_mode_r == DEPTH_4BIT) || (depth_mode_r == DEPTH_3BIT);
  assign full   = ({1'b0, pix_cnt_r} + 14'd1) >= {1'b0, pix_per_pkt_r};
  assign close  = full || (in_end_of_frame && (packet_mode_r == PKT_WINDOW));
  assign hdr    = (pix_cnt_r == 13'd0);

  // payload bytes and next pair state
  always_comb begin
    pay         = '0;
    pay_n       = CNT_W'(3);
    pending_nxt = 8'd0;
    phase_nxt   = 1'b0;
    if (!reduce) begin
      pay[0] = in_red;
      pay[1] = in_green;
      pay[2] = in_blue;
    end else if (!phase_r) begin
      pay[0] = 8'({4'd0, cr} << NIBBLE_SHIFT) | {4'd0, cg};
      if (close) begin
        pay[1] = pend_new;
        pay_n  = CNT_W'(2);
      end else begin
        pay_n       = CNT_W'(1);
        pending_nxt = pend_new;
        phase_nxt   = 1'b1;
      end
    end else begin
      pay[0] = pending_r | {4'd0, cr};
      pay[1] = 8'({4'd0, cg} << NIBBLE_SHIFT) | {4'd0, cb};
      pay_n  = CNT_W'(2);
    end
    if (in_end_of_frame) begin
      pending_nxt = 8'd0;
      phase_nxt   = 1'b0;
    end
  end

  // packet counters
  always_comb begin
    if (close) begin
      pix_cnt_nxt = 13'd0;
      pkt_num_nxt = pkt_num_r + 8'd1;
    end else begin
      pix_cnt_nxt = pix_cnt_r + 13'd1;
      pkt_num_nxt = pkt_num_r;
    end
    if (in_end_of_frame) begin
      pix_cnt_nxt = 13'd0;
      pkt_num_nxt = 8'd0;
    end
  end

  // command build: header bytes lead when the packet is still empty
  always_comb begin
    cmd         = '0;
    cmd.has_hdr = hdr;
    cmd.last    = close;
    if (hdr) begin
      cmd.bytes[0] = proto_type_r;
      cmd.bytes[1] = pkt_num_r;
      cmd.bytes[2] = pay[0];
      cmd.bytes[3] = pay[1];
      cmd.bytes[4] = pay[2];
      cmd.n        = pay_n + CNT_W'(2);
    end else begin
      cmd.bytes[0] = pay[0];
      cmd.bytes[1] = pay[1];
      cmd.bytes[2] = pay[2];
      cmd.n        = pay_n;
    end
  end

  // packet state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 8'd0;
      phase_r   <= 1'b0;
      pix_cnt_r <= 13'd0;
      pkt_num_r <= 8'd0;
    end else if (push) begin
      pending_r <= pending_nxt;
      phase_r   <= phase_nxt;
      pix_cnt_r <= pix_cnt_nxt;
      pkt_num_r <= pkt_num_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/ppp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppp_queue
// Short command queue that decouples pixel acceptance from byte output.
// ----------------------------------------------------------------------------
module ppp_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ppp_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output logic               full,
  output logic               q_valid,
  output ppp_pkg::cmd_t      q_cmd
);
  import ppp_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0] count_r;

  assign full    = (count_r == CNT_QW'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = entry_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_QW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_QW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/ppp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppp_back
// Steps through the current command one byte per cycle, unless out_stall
// holds the output register; the next command loads as the last byte leaves.
// ----------------------------------------------------------------------------
module ppp_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire ppp_pkg::cmd_t q_cmd,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         out_byte,
  output logic               out_is_header,
  output logic               out_last_of_packet
);
  import ppp_pkg::*;

  cmd_t             cur_r;
  logic             cur_valid_r;
  logic [CNT_W-1:0] pos_r;
  logic             out_valid_r;
  logic [7:0]       byte_r, byte_nxt;
  logic             hdr_r, last_r;

  logic out_load, emit, is_end, cur_free;

  assign out_load = !out_valid_r || !out_stall;
  assign emit     = out_load && cur_valid_r;
  assign is_end   = (pos_r == cur_r.n - CNT_W'(1));
  assign cur_free = !cur_valid_r || (emit && is_end);
  assign pop      = cur_free && q_valid;

  // byte select
  always_comb begin
    case (pos_r)
      CNT_W'(0): byte_nxt = cur_r.bytes[0];
      CNT_W'(1): byte_nxt = cur_r.bytes[1];
      CNT_W'(2): byte_nxt = cur_r.bytes[2];
      CNT_W'(3): byte_nxt = cur_r.bytes[3];
      CNT_W'(4): byte_nxt = cur_r.bytes[4];
      default:   byte_nxt = 8'd0;
    endcase
  end

  // command sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      pos_r       <= '0;
    end else if (pop) begin
      cur_valid_r <= 1'b1;
      pos_r       <= '0;
    end else if (emit && is_end) begin
      cur_valid_r <= 1'b0;
    end else if (emit) begin
      pos_r <= pos_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_cmd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= cur_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r <= byte_nxt;
      hdr_r  <= cur_r.has_hdr && (pos_r < CNT_W'(2));
      last_r <= cur_r.last && is_end;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = byte_r;
  assign out_is_header      = hdr_r;
  assign out_last_of_packet = last_r;

endmodule
`default_nettype wire

// File: sv/pixel_pack_packetizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_pack_packetizer
// RGB888 pixel to packet byte stream, with optional 4- or 3-bit reduce.
// ----------------------------------------------------------------------------
// Input channel: one pixel per transfer (in_valid high, in_stall low),
// with in_end_of_frame on the final pixel of a frame.
// Output channel: one stream byte per transfer, flagged as header or as
// the last byte of a packet. Header bytes precede the first pixel of each
// packet.
// Config: write cfg_wdata to register cfg_index when cfg_we is high, only
// while the block is idle.
// Path: a pixel's command passes the queue and the current-command register
// before its first byte enters the output register. Each pixel causes one to
// five bytes (three in copy mode, 1.5 average in reduce mode, plus two per
// packet for the header); the output byte sequencer sets their pace.
// A two-entry command queue lets pixels be taken while bytes drain.
// Reset: clears configuration to defaults, packet state, queue and output.
// Receiver stall: the output register holds; the queue fills and then
// in_stall rises until bytes move again.
// ----------------------------------------------------------------------------
module pixel_pack_packetizer #(
  parameter int unsigned NIBBLE_SHIFT = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  input  wire logic        in_end_of_frame,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_is_header,
  output logic             out_last_of_packet
);
  import ppp_pkg::*;

  logic push, q_full, q_valid, pop;
  cmd_t push_cmd, q_cmd;

  assign in_stall = q_full;

  // pixel front end
  ppp_front #(
    .NIBBLE_SHIFT(NIBBLE_SHIFT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_end_of_frame(in_end_of_frame),
    .q_full         (q_full),
    .push           (push),
    .cmd            (push_cmd)
  );

  // command queue
  ppp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .full    (q_full),
    .q_valid (q_valid),
    .q_cmd   (q_cmd)
  );

  // byte back end
  ppp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_cmd             (q_cmd),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_is_header     (out_is_header),
    .out_last_of_packet(out_last_of_packet)
  );

  // every command carries one to five bytes
  a_cmd_len: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_cmd.n >= CNT_W'(1) && push_cmd.n <= CNT_W'(MAX_BYTES)))
    else $error("command byte count out of range");

  // a header byte never closes a packet
  a_hdr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_header && out_last_of_packet))
    else $error("header byte flagged as packet end");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a pop only happens with a queued command
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("queue popped while empty");

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pixel_pack_packetizer. A driver feeds pixels from a
// queue over the valid/stall input channel. Each accepted pixel runs through
// a packing predictor that keeps its own copy of the packet state and the
// registers. The predicted stream bytes are queued, and the monitor checks
// every byte transfer against the oldest one. Directed cases come first,
// then random phases with varying registers, idling and a long output hold.
// ----------------------------------------------------------------------------
module tb;
  import ppp_pkg::*;

  localparam logic [1:0]  DEPTH_SPARE    = 2'd3;  // unused depth code
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PHASE_PIXELS   = 17;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       eof;
  } pixel_t;

  typedef struct packed {
    logic [7:0] data;
    logic       hdr;
    logic       last;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_DEPTH_MODE;
  logic [12:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_red = '0;
  logic [7:0]  in_green = '0;
  logic [7:0]  in_blue = '0;
  logic        in_end_of_frame = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_is_header;
  logic        out_last_of_packet;

  // register mirrors
  logic [1:0]  depth_sel = DEPTH_RST;
  logic        win_mode = PKT_ROW;
  logic [12:0] pkt_pixels = PPP_RST;
  logic [7:0]  proto_byte = '0;

  // packet state mirrors
  logic [7:0]  held_blue = '0;
  logic        odd_pixel = 1'b0;
  logic [12:0] pix_in_pkt = '0;
  logic [7:0]  pkt_num = '0;

  pixel_t       pixel_q[$];
  stream_byte_t byte_q[$];

  int unsigned pixels_queued = 0;
  int unsigned pixels_taken = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_left = 0;
  logic        pix_taken = 1'b0;

  pixel_pack_packetizer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_red             (in_red),
    .in_green           (in_green),
    .in_blue            (in_blue),
    .in_end_of_frame    (in_end_of_frame),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_is_header      (out_is_header),
    .out_last_of_packet (out_last_of_packet)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // multiply, add and shift rounding of one channel
  function automatic logic [3:0] quantize_chan(input logic [7:0] c, input logic [1:0] mode);
    int unsigned v;
    if (mode == DEPTH_3BIT) begin
      v = (c * 225 + 4096) >> 13;
    end else begin
      v = (c * 15 + 135) >> 8;
    end
    return v[3:0];
  endfunction

  function automatic void expect_byte(input logic [7:0] data, input logic hdr,
                                      input logic last);
    stream_byte_t sb;
    sb.data = data;
    sb.hdr  = hdr;
    sb.last = last;
    byte_q.push_back(sb);
  endfunction

  // stream bytes caused by one pixel, updating the packet state
  function automatic void pack_pixel(input pixel_t p);
    logic [3:0] cr, cg, cb;
    logic       reduce, close;
    reduce = (depth_sel == DEPTH_4BIT) || (depth_sel == DEPTH_3BIT);
    close  = (int'(pix_in_pkt) + 1 >= int'(pkt_pixels)) ||
             (p.eof && win_mode == PKT_WINDOW);
    // header goes out ahead of the first pixel of a packet
    if (pix_in_pkt == 0) begin
      expect_byte(proto_byte, 1'b1, 1'b0);
      expect_byte(pkt_num, 1'b1, 1'b0);
    end
    if (!reduce) begin
      odd_pixel = 1'b0;
      held_blue = '0;
      expect_byte(p.red, 1'b0, 1'b0);
      expect_byte(p.green, 1'b0, 1'b0);
      expect_byte(p.blue, 1'b0, close);
    end else begin
      cr = quantize_chan(p.red, depth_sel);
      cg = quantize_chan(p.green, depth_sel);
      cb = quantize_chan(p.blue, depth_sel);
      if (!odd_pixel) begin
        expect_byte({cr, cg}, 1'b0, 1'b0);
        held_blue = {cb, 4'h0};
        odd_pixel = 1'b1;
        // packet closing on an even pixel flushes the held nibble
        if (close) begin
          expect_byte(held_blue, 1'b0, 1'b1);
          held_blue = '0;
          odd_pixel = 1'b0;
        end
      end else begin
        expect_byte(held_blue | {4'h0, cr}, 1'b0, 1'b0);
        expect_byte({cg, cb}, 1'b0, close);
        held_blue = '0;
        odd_pixel = 1'b0;
      end
    end
    if (close) begin
      pix_in_pkt = '0;
      pkt_num    = pkt_num + 8'd1;
    end else begin
      pix_in_pkt = pix_in_pkt + 13'd1;
    end
    // frame end restarts everything
    if (p.eof) begin
      pix_in_pkt = '0;
      odd_pixel  = 1'b0;
      held_blue  = '0;
      pkt_num    = '0;
    end
  endfunction

  function automatic void log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void offer(input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b, input logic eof);
    pixel_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    p.eof   = eof;
    pixel_q.push_back(p);
    pixels_queued++;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEPTH_MODE:  depth_sel  = val[1:0];
      REG_PACKET_MODE: win_mode   = val[0];
      REG_PIX_PER_PKT: pkt_pixels = val;
      REG_PROTO_TYPE:  proto_byte = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_mode(input logic [1:0] depth, input logic mode,
                          input logic [12:0] size, input logic [7:0] proto);
    write_reg(REG_DEPTH_MODE, {11'd0, depth});
    write_reg(REG_PACKET_MODE, {12'd0, mode});
    write_reg(REG_PIX_PER_PKT, size);
    write_reg(REG_PROTO_TYPE, {5'd0, proto});
  endtask

  // wait until every pixel is taken and every byte has come out
  task automatic settle();
    do @(negedge clk); while (pixels_taken != pixels_queued || byte_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_idling(input int unsigned sel);
    case (sel)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 65; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 65; end
      default: begin src_idle_pct = 26; sink_stall_pct = 26; end
    endcase
  endtask

  // pixel driver: new transfer only after the previous one was taken
  always @(negedge clk) begin : drive_pixels
    pixel_t nxt;
    if (rst_n && (!in_valid || pix_taken)) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = pixel_q.pop_front();
        in_valid        <= 1'b1;
        in_red          <= nxt.red;
        in_green        <= nxt.green;
        in_blue         <= nxt.blue;
        in_end_of_frame <= nxt.eof;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // pixel transfers feed the predictor
  always @(posedge clk) begin : watch_pixels
    pixel_t p;
    pix_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      p.red   = in_red;
      p.green = in_green;
      p.blue  = in_blue;
      p.eof   = in_end_of_frame;
      pack_pixel(p);
      pixels_taken++;
    end
  end

  // byte transfers checked against the oldest expected byte
  always @(posedge clk) begin : check_bytes
    stream_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (byte_q.size() == 0) begin
        log_mismatch($sformatf("unexpected byte %02h hdr %0b last %0b",
                               out_byte, out_is_header, out_last_of_packet));
      end else begin
        want = byte_q.pop_front();
        if (want.data !== out_byte || want.hdr !== out_is_header ||
            want.last !== out_last_of_packet) begin
          log_mismatch($sformatf("byte %02h hdr %0b last %0b, expected %02h hdr %0b last %0b",
                                 out_byte, out_is_header, out_last_of_packet,
                                 want.data, want.hdr, want.last));
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned n, len;
    logic [12:0] size;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    set_idling(0);

    // reset registers; row-wise frame end drops the open packet
    offer(8'h00, 8'hFF, 8'h10, 1'b0);
    offer(8'h7F, 8'h80, 8'h01, 1'b1);
    settle();

    // 4-bit windows of four, partial packet closed on its held nibble
    set_mode(DEPTH_4BIT, PKT_WINDOW, 13'd4, 8'hA5);
    offer(8'h00, 8'h00, 8'h00, 1'b0);
    offer(8'hFF, 8'hFF, 8'hFF, 1'b0);
    offer(8'h80, 8'h7F, 8'h08, 1'b0);
    offer(8'h11, 8'hEE, 8'h88, 1'b0);
    offer(8'hFF, 8'h00, 8'hFF, 1'b1);
    settle();

    // 3-bit row-wise, frame ends before the packet fills
    set_mode(DEPTH_3BIT, PKT_ROW, 13'd4, 8'h5A);
    offer(8'hFF, 8'h24, 8'h00, 1'b0);
    offer(8'h92, 8'hFF, 8'h49, 1'b0);
    offer(8'h00, 8'hB6, 8'hDB, 1'b1);
    settle();

    // leave a held nibble and a partly filled packet behind
    set_mode(DEPTH_4BIT, PKT_ROW, 13'd6, 8'hC3);
    offer(8'h12, 8'h34, 8'h56, 1'b0);
    offer(8'h9A, 8'hBC, 8'hDE, 1'b0);
    offer(8'hF0, 8'h0F, 8'hC8, 1'b0);
    settle();

    // copy mode drops the nibble; size below the count closes at once
    set_mode(DEPTH_COPY, PKT_ROW, 13'd2, 8'h3C);
    offer(8'h01, 8'h02, 8'h03, 1'b0);
    offer(8'hFE, 8'hFD, 8'hFC, 1'b0);
    offer(8'h55, 8'hAA, 8'h5A, 1'b1);
    settle();

    // spare depth code copies; size zero closes after every pixel
    set_mode(DEPTH_SPARE, PKT_WINDOW, 13'd0, 8'h00);
    offer(8'hAA, 8'h55, 8'h00, 1'b0);
    offer(8'hFF, 8'h80, 8'h7F, 1'b1);
    settle();

    // size one in reduce mode
    set_mode(DEPTH_4BIT, PKT_ROW, 13'd1, 8'hFF);
    offer(8'h08, 8'h09, 8'hF7, 1'b0);
    offer(8'hF8, 8'h87, 8'h78, 1'b0);
    offer(8'h00, 8'hFF, 8'h00, 1'b1);
    settle();

    // packet size 4096, flushed by the window frame end
    set_mode(DEPTH_3BIT, PKT_WINDOW, 13'd4096, 8'h81);
    offer(8'h23, 8'h24, 8'h25, 1'b0);
    offer(8'hDA, 8'hDB, 8'hDC, 1'b0);
    offer(8'h6D, 8'h6E, 8'h92, 1'b1);
    settle();

    // random phases: fresh registers and idling for each
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(7))
        0: size = 13'd4096;
        1: size = 13'($urandom_range(1, 15));
        default: size = 13'(2 * $urandom_range(1, 8));
      endcase
      set_mode(2'($urandom_range(3)), 1'($urandom_range(1)), size,
               8'($urandom_range(255)));
      set_idling(ph % 4);
      if (ph == 4) hold_left = HOLD_CYCLES;
      n = 0;
      while (n < PHASE_PIXELS) begin
        len = $urandom_range(1, 24);
        for (int k = 0; k < len && n < PHASE_PIXELS; k++) begin
          offer(rand_chan(), rand_chan(), rand_chan(), k == len - 1);
          n++;
        end
      end
      settle();
    end

    if (mismatches == 0 && byte_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
